// ===== src/dcfl_pkg.sv =====
// Shared constants, codes and types of the descriptor chain free list.
package dcfl_pkg;

  localparam int MAX_ENTRIES_DEF = 256;
  localparam int IDX_W_DEF       = 8;
  localparam int PORT_IDX_W      = 8;
  localparam int LEN_W           = 9;
  localparam int KIND_W          = 2;
  localparam int STATUS_W        = 2;
  localparam int CFG_W           = 4;
  localparam int SIZE_LOG_LO     = 2;
  localparam int SIZE_LOG_HI     = 8;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_REBUILD = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SPACE = 2'd1,
    STATUS_BROKEN   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ALLOC_RD,
    ST_ALLOC_WT,
    ST_FREE_RD,
    ST_FREE_WT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic link_we;
    logic mark_we;
    logic mark_wdata;
  } mem_ctl_t;

endpackage

// ===== src/dcfl_req_if.sv =====
// Request channel: valid/ready handshake carrying one free-list request.
interface dcfl_req_if;
  logic                           valid;
  logic                           ready;
  logic [dcfl_pkg::KIND_W-1:0]     kind;
  logic [dcfl_pkg::LEN_W-1:0]      chain_length;
  logic [dcfl_pkg::PORT_IDX_W-1:0] chain_head;

  modport source (output valid, output kind, output chain_length, output chain_head,
                  input ready);
  modport sink (input valid, input kind, input chain_length, input chain_head,
                output ready);
endinterface

// ===== src/dcfl_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one free-list result.
interface dcfl_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [dcfl_pkg::STATUS_W-1:0]   status;
  logic [dcfl_pkg::PORT_IDX_W-1:0] head_index;
  logic [dcfl_pkg::LEN_W-1:0]      free_count;

  modport source (output valid, output status, output head_index, output free_count,
                  input ready);
  modport sink (input valid, input status, input head_index, input free_count,
                output ready);
endinterface

// ===== src/dcfl_tables.sv =====
// Link and chained-mark memories, one shared address, registered read data.
module dcfl_tables #(
  parameter int IDX_W = dcfl_pkg::IDX_W_DEF
) (
  input  logic               clk,
  input  dcfl_pkg::mem_ctl_t ctl_i,
  input  logic [IDX_W-1:0]   addr_i,
  input  logic [IDX_W-1:0]   link_wdata_i,
  output logic [IDX_W-1:0]   link_rd_o,
  output logic               mark_rd_o
);

  localparam int DEPTH = 1 << IDX_W;

  logic [IDX_W-1:0] link_mem_r [DEPTH];
  logic             mark_mem_r [DEPTH];
  logic [IDX_W-1:0] link_rd_r;
  logic             mark_rd_r;

  always_ff @(posedge clk) begin
    if (ctl_i.link_we) begin
      link_mem_r[addr_i] <= link_wdata_i;
    end
    if (ctl_i.rd_en) begin
      link_rd_r <= link_mem_r[addr_i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.mark_we) begin
      mark_mem_r[addr_i] <= ctl_i.mark_wdata;
    end
    if (ctl_i.rd_en) begin
      mark_rd_r <= mark_mem_r[addr_i];
    end
  end

  assign link_rd_o = link_rd_r;
  assign mark_rd_o = mark_rd_r;

endmodule

// ===== src/dcfl_ctrl.sv =====
// Sequencer that walks chains through the tables with one shared step counter.
module dcfl_ctrl #(
  parameter int IDX_W = dcfl_pkg::IDX_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [dcfl_pkg::LEN_W-1:0] size_i,
  input  logic [IDX_W-1:0]           mask_i,
  dcfl_req_if.sink                   in_req,
  dcfl_rsp_if.source                 out_rsp,
  output dcfl_pkg::mem_ctl_t         mem_ctl_o,
  output logic [IDX_W-1:0]           mem_addr_o,
  output logic [IDX_W-1:0]           link_wdata_o,
  input  logic [IDX_W-1:0]           link_rd_i,
  input  logic                       mark_rd_i
);

  localparam logic [dcfl_pkg::LEN_W-1:0] FULL_COUNT = dcfl_pkg::LEN_W'(1 << IDX_W);

  dcfl_pkg::state_t                   state_r, state_nxt;
  logic                               init_r, init_nxt;
  logic [dcfl_pkg::LEN_W-1:0]         cnt_r, cnt_nxt;
  logic [IDX_W-1:0]                   cur_r, cur_nxt;
  logic [IDX_W-1:0]                   start_r, start_nxt;
  logic [IDX_W-1:0]                   list_head_r, list_head_nxt;
  logic [dcfl_pkg::LEN_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]                   sweep_mask_r, sweep_mask_nxt;
  dcfl_pkg::status_t                  res_status_r, res_status_nxt;
  logic [IDX_W-1:0]                   res_head_r, res_head_nxt;
  logic                               out_valid_r, out_valid_nxt;
  dcfl_pkg::status_t                  out_status_r, out_status_nxt;
  logic [IDX_W-1:0]                   out_head_r, out_head_nxt;
  logic [dcfl_pkg::LEN_W-1:0]         out_count_r, out_count_nxt;

  logic                               accept;
  dcfl_pkg::kind_t                    kind;
  logic                               alloc_bad;
  logic                               sweep_end;
  logic                               out_free;
  logic [IDX_W-1:0]                   sweep_idx;
  logic [IDX_W-1:0]                   link_masked;
  logic [dcfl_pkg::LEN_W:0]           free_sum;

  assign kind        = dcfl_pkg::kind_t'(in_req.kind);
  assign accept      = in_req.valid && in_req.ready;
  assign alloc_bad   = (in_req.chain_length == '0) || (in_req.chain_length > count_r);
  assign sweep_idx   = cnt_r[IDX_W-1:0];
  assign sweep_end   = &sweep_idx;
  assign out_free    = !out_valid_r || out_rsp.ready;
  assign link_masked = link_rd_i & mask_i;
  assign free_sum    = {1'b0, count_r} + {1'b0, cnt_r};

  assign in_req.ready       = (state_r == dcfl_pkg::ST_IDLE);
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.status     = out_status_r;
  assign out_rsp.head_index = dcfl_pkg::PORT_IDX_W'(out_head_r);
  assign out_rsp.free_count = out_count_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dcfl_pkg::ST_SWEEP: begin
        if (sweep_end) begin
          state_nxt = init_r ? dcfl_pkg::ST_IDLE : dcfl_pkg::ST_FIN;
        end
      end
      dcfl_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            dcfl_pkg::KIND_ALLOC:   state_nxt = alloc_bad ? dcfl_pkg::ST_FIN
                                                          : dcfl_pkg::ST_ALLOC_RD;
            dcfl_pkg::KIND_FREE:    state_nxt = dcfl_pkg::ST_FREE_RD;
            dcfl_pkg::KIND_REBUILD: state_nxt = dcfl_pkg::ST_SWEEP;
            dcfl_pkg::KIND_NONE:    state_nxt = dcfl_pkg::ST_FIN;
          endcase
        end
      end
      dcfl_pkg::ST_ALLOC_RD: state_nxt = dcfl_pkg::ST_ALLOC_WT;
      dcfl_pkg::ST_ALLOC_WT: begin
        state_nxt = (cnt_r == '0) ? dcfl_pkg::ST_FIN : dcfl_pkg::ST_ALLOC_RD;
      end
      dcfl_pkg::ST_FREE_RD: state_nxt = dcfl_pkg::ST_FREE_WT;
      dcfl_pkg::ST_FREE_WT: begin
        if (!mark_rd_i || (cnt_r == size_i)) begin
          state_nxt = dcfl_pkg::ST_FIN;
        end else begin
          state_nxt = dcfl_pkg::ST_FREE_RD;
        end
      end
      dcfl_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = dcfl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dcfl_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory controls and result register.
  always_comb begin
    init_nxt       = init_r;
    cnt_nxt        = cnt_r;
    cur_nxt        = cur_r;
    start_nxt      = start_r;
    list_head_nxt  = list_head_r;
    count_nxt      = count_r;
    sweep_mask_nxt = sweep_mask_r;
    res_status_nxt = res_status_r;
    res_head_nxt   = res_head_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_head_nxt   = out_head_r;
    out_count_nxt  = out_count_r;
    mem_ctl_o      = '0;
    mem_addr_o     = cur_r;
    link_wdata_o   = '0;

    unique case (state_r)
      dcfl_pkg::ST_SWEEP: begin
        // Every mark is cleared; only entries inside the size get fresh links.
        mem_addr_o           = sweep_idx;
        mem_ctl_o.mark_we    = 1'b1;
        mem_ctl_o.mark_wdata = 1'b0;
        mem_ctl_o.link_we    = ((sweep_idx & ~sweep_mask_r) == '0);
        link_wdata_o         = IDX_W'(sweep_idx + 1'b1) & sweep_mask_r;
        cnt_nxt              = dcfl_pkg::LEN_W'(cnt_r + 1'b1);
        if (sweep_end) begin
          init_nxt       = 1'b0;
          res_status_nxt = dcfl_pkg::STATUS_OK;
          res_head_nxt   = '0;
        end
      end
      dcfl_pkg::ST_IDLE: begin
        if (accept) begin
          res_status_nxt = dcfl_pkg::STATUS_OK;
          res_head_nxt   = '0;
          unique case (kind)
            dcfl_pkg::KIND_ALLOC: begin
              if (alloc_bad) begin
                res_status_nxt = dcfl_pkg::STATUS_NO_SPACE;
              end else begin
                // The count is known to fall by n, so it is taken off up front.
                cur_nxt      = list_head_r & mask_i;
                res_head_nxt = list_head_r & mask_i;
                count_nxt    = count_r - in_req.chain_length;
                cnt_nxt      = in_req.chain_length - 1'b1;
              end
            end
            dcfl_pkg::KIND_FREE: begin
              cur_nxt   = in_req.chain_head[IDX_W-1:0] & mask_i;
              start_nxt = in_req.chain_head[IDX_W-1:0] & mask_i;
              cnt_nxt   = '0;
            end
            dcfl_pkg::KIND_REBUILD: begin
              cnt_nxt        = '0;
              sweep_mask_nxt = mask_i;
              list_head_nxt  = '0;
              count_nxt      = size_i;
            end
            dcfl_pkg::KIND_NONE: begin
            end
          endcase
        end
      end
      dcfl_pkg::ST_ALLOC_RD: begin
        mem_ctl_o.rd_en      = 1'b1;
        mem_ctl_o.mark_we    = 1'b1;
        mem_ctl_o.mark_wdata = (cnt_r != '0);
      end
      dcfl_pkg::ST_ALLOC_WT: begin
        if (cnt_r == '0) begin
          // Last entry: the free list resumes at its old link, the chain ends here.
          list_head_nxt     = link_masked;
          mem_ctl_o.link_we = 1'b1;
          link_wdata_o      = '0;
        end else begin
          cur_nxt = link_masked;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      dcfl_pkg::ST_FREE_RD: begin
        mem_ctl_o.rd_en = 1'b1;
        cnt_nxt         = dcfl_pkg::LEN_W'(cnt_r + 1'b1);
      end
      dcfl_pkg::ST_FREE_WT: begin
        if (!mark_rd_i) begin
          mem_ctl_o.link_we = 1'b1;
          link_wdata_o      = list_head_r & mask_i;
          list_head_nxt     = start_r;
          count_nxt         = (free_sum > {1'b0, size_i}) ? size_i
                                                          : free_sum[dcfl_pkg::LEN_W-1:0];
        end else if (cnt_r == size_i) begin
          res_status_nxt = dcfl_pkg::STATUS_BROKEN;
        end else begin
          cur_nxt = link_masked;
        end
      end
      dcfl_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_head_nxt   = res_head_r;
          out_count_nxt  = count_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dcfl_pkg::ST_SWEEP;
      init_r       <= 1'b1;
      cnt_r        <= '0;
      list_head_r  <= '0;
      count_r      <= FULL_COUNT;
      sweep_mask_r <= '1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_r       <= init_nxt;
      cnt_r        <= cnt_nxt;
      list_head_r  <= list_head_nxt;
      count_r      <= count_nxt;
      sweep_mask_r <= sweep_mask_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    start_r      <= start_nxt;
    res_status_r <= res_status_nxt;
    res_head_r   <= res_head_nxt;
    out_status_r <= out_status_nxt;
    out_head_r   <= out_head_nxt;
    out_count_r  <= out_count_nxt;
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != dcfl_pkg::ST_IDLE))
    else $error("request transfer did not start a sequence");

  a_walk_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dcfl_pkg::ST_FREE_WT) |-> ((cnt_r != '0) && (cnt_r <= size_i)))
    else $error("free walk length outside one to size");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("free count above table depth");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == dcfl_pkg::ST_FIN))
    else $error("result raised outside the finish step");

endmodule

// ===== src/descriptor_chain_free_list.sv =====
// Allocate walks n entries, free walks an L-entry chain, and rebuild sweeps all 2^IDX_W entries
// (2^IDX_W = 256 at the default depth); a failed or unused request goes straight to the finish step.
// Requests are handled one at a time; each chain entry passes a table read step and a use step.
// The next request is taken while the previous result still waits on the output register.
// Reset: synchronous, active low; a clearing pass over all 2^IDX_W entries (256 by default) then
// rebuilds the tables before the first request transfer; configuration writes are taken.
module descriptor_chain_free_list #(
  parameter int MAX_ENTRIES = dcfl_pkg::MAX_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [dcfl_pkg::CFG_W-1:0] cfg_wdata,
  dcfl_req_if.sink                   in_req,
  dcfl_rsp_if.source                 out_rsp
);

  localparam int LOG_MAX = $clog2(MAX_ENTRIES + 1) - 1;
  localparam int IDX_W   = (LOG_MAX > dcfl_pkg::SIZE_LOG_HI) ? dcfl_pkg::SIZE_LOG_HI : LOG_MAX;

  logic [dcfl_pkg::CFG_W-1:0] size_log2_r;
  logic [dcfl_pkg::CFG_W-1:0] size_log;
  logic [dcfl_pkg::LEN_W-1:0] size;
  logic [IDX_W-1:0]           mask;
  dcfl_pkg::mem_ctl_t         mem_ctl;
  logic [IDX_W-1:0]           mem_addr;
  logic [IDX_W-1:0]           link_wdata;
  logic [IDX_W-1:0]           link_rd;
  logic                       mark_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_log2_r <= dcfl_pkg::CFG_RESET;
    end else if (cfg_we) begin
      size_log2_r <= cfg_wdata;
    end
  end

  // The register is clamped to the supported range and to the table depth.
  always_comb begin
    size_log = size_log2_r;
    if (size_log < dcfl_pkg::CFG_W'(dcfl_pkg::SIZE_LOG_LO)) begin
      size_log = dcfl_pkg::CFG_W'(dcfl_pkg::SIZE_LOG_LO);
    end
    if (size_log > dcfl_pkg::CFG_W'(IDX_W)) begin
      size_log = dcfl_pkg::CFG_W'(IDX_W);
    end
  end

  assign size = dcfl_pkg::LEN_W'(1) << size_log;
  assign mask = IDX_W'(size - 1'b1);

  dcfl_tables #(
    .IDX_W (IDX_W)
  ) u_tables (
    .clk          (clk),
    .ctl_i        (mem_ctl),
    .addr_i       (mem_addr),
    .link_wdata_i (link_wdata),
    .link_rd_o    (link_rd),
    .mark_rd_o    (mark_rd)
  );

  dcfl_ctrl #(
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .size_i       (size),
    .mask_i       (mask),
    .in_req       (in_req),
    .out_rsp      (out_rsp),
    .mem_ctl_o    (mem_ctl),
    .mem_addr_o   (mem_addr),
    .link_wdata_o (link_wdata),
    .link_rd_i    (link_rd),
    .mark_rd_i    (mark_rd)
  );

endmodule
